[rtl/core/tcaf_pkg.sv]
package tcaf_pkg;

   localparam int CLASS_DEPTH   = 16;
   localparam int PAYLOAD_WIDTH = 32;
   localparam int NUM_CLASSES   = 2;
   localparam int STAMP_MOD     = 4 * CLASS_DEPTH;
   localparam int PTR_W         = (CLASS_DEPTH > 1) ? $clog2(CLASS_DEPTH) : 1;
   localparam int CNT_W         = $clog2(CLASS_DEPTH + 1);
   localparam int STAMP_W       = $clog2(STAMP_MOD);
   localparam int ENTRY_W       = STAMP_W + PAYLOAD_WIDTH;

   typedef enum logic [2:0] {
      KIND_PUSH0   = 3'd0,
      KIND_PUSH1   = 3'd1,
      KIND_POP0    = 3'd2,
      KIND_POP1    = 3'd3,
      KIND_POP_ANY = 3'd4
   } kind_type;

   typedef enum logic [1:0] {
      STATUS_OK    = 2'd0,
      STATUS_EMPTY = 2'd1,
      STATUS_FULL  = 2'd2
   } status_type;

   typedef enum logic {
      ST_IDLE = 1'b0,
      ST_EXEC = 1'b1
   } state_type;

   typedef struct packed {
      logic [2:0]               kind;
      logic [PAYLOAD_WIDTH-1:0] payload_in;
   } req_type;

   typedef struct packed {
      logic [PAYLOAD_WIDTH-1:0] payload_out;
      logic                     popped_class;
      logic [1:0]               status;
   } rsp_type;

   typedef struct packed {
      logic capture;
      logic execute;
   } ctl_cmd_type;

   function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
      logic [PTR_W-1:0] r;
      if (p == PTR_W'(CLASS_DEPTH - 1)) begin
         r = '0;
      end else begin
         r = p + 1'b1;
      end
      return r;
   endfunction

endpackage

[rtl/core/tcaf_ram.sv]
module tcaf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                        clock,
   input  logic                                        wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                            wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                            rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/core/tcaf_ctrl.sv]
module tcaf_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   output tcaf_pkg::ctl_cmd_type cmd
);
   import tcaf_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd  = '0;
      busy = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            cmd.capture = start;
         end
         ST_EXEC: begin
            cmd.execute = 1'b1;
            busy        = 1'b1;
         end
         default: begin
            busy = 1'b1;
         end
      endcase
   end

endmodule

[rtl/core/tcaf_datapath.sv]
module tcaf_datapath (
   input  logic                  clock,
   input  logic                  reset,
   input  tcaf_pkg::ctl_cmd_type cmd,
   input  tcaf_pkg::req_type     req_item,
   output logic                  rsp_valid,
   output tcaf_pkg::rsp_type     rsp_item
);
   import tcaf_pkg::*;

   req_type            req_ff;
   logic [PTR_W-1:0]   head_ff  [NUM_CLASSES];
   logic [PTR_W-1:0]   head_in  [NUM_CLASSES];
   logic [PTR_W-1:0]   tail_ff  [NUM_CLASSES];
   logic [PTR_W-1:0]   tail_in  [NUM_CLASSES];
   logic [CNT_W-1:0]   count_ff [NUM_CLASSES];
   logic [CNT_W-1:0]   count_in [NUM_CLASSES];
   logic [STAMP_W-1:0] arrival_ff;
   logic [STAMP_W-1:0] arrival_in;
   logic               rsp_valid_ff;
   logic               rsp_valid_in;
   rsp_type            rsp_ff;
   rsp_type            rsp_in;

   logic [ENTRY_W-1:0] rd_data  [NUM_CLASSES];
   logic               wr_en    [NUM_CLASSES];
   logic [ENTRY_W-1:0] wr_data;

   logic [STAMP_W-1:0] stamp0;
   logic [STAMP_W-1:0] stamp1;
   logic [STAMP_W:0]   stamp_diff;
   logic               older0;
   logic               push_req;
   logic               pop_req;
   logic               push_cls;
   logic               pop_cls;

   for (genvar c = 0; c < NUM_CLASSES; c++) begin : g_class
      tcaf_ram #(
         .WIDTH(ENTRY_W),
         .DEPTH(CLASS_DEPTH)
      ) u_ram (
         .clock  (clock),
         .wr_en  (wr_en[c]),
         .wr_addr(tail_ff[c]),
         .wr_data(wr_data),
         .rd_addr(head_ff[c]),
         .rd_data(rd_data[c])
      );
   end

   assign wr_data = {arrival_ff, req_ff.payload_in};
   assign stamp0  = rd_data[0][PAYLOAD_WIDTH +: STAMP_W];
   assign stamp1  = rd_data[1][PAYLOAD_WIDTH +: STAMP_W];

   always_comb begin
      if (stamp1 >= stamp0) begin
         stamp_diff = {1'b0, stamp1} - {1'b0, stamp0};
      end else begin
         stamp_diff = {1'b0, stamp1} + (STAMP_W + 1)'(STAMP_MOD) - {1'b0, stamp0};
      end
      older0 = (stamp_diff != '0) && (stamp_diff < (STAMP_W + 1)'(STAMP_MOD / 2));
   end

   always_comb begin
      push_req = 1'b0;
      pop_req  = 1'b0;
      push_cls = 1'b0;
      pop_cls  = 1'b0;
      unique case (kind_type'(req_ff.kind))
         KIND_PUSH0: begin
            push_req = 1'b1;
         end
         KIND_PUSH1: begin
            push_req = 1'b1;
            push_cls = 1'b1;
         end
         KIND_POP0: begin
            pop_req = 1'b1;
         end
         KIND_POP1: begin
            pop_req = 1'b1;
            pop_cls = 1'b1;
         end
         KIND_POP_ANY: begin
            pop_req = 1'b1;
            priority if (count_ff[0] == '0) begin
               pop_cls = 1'b1;
            end else if (count_ff[1] == '0) begin
               pop_cls = 1'b0;
            end else begin
               pop_cls = !older0;
            end
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      head_in      = head_ff;
      tail_in      = tail_ff;
      count_in     = count_ff;
      arrival_in   = arrival_ff;
      wr_en[0]     = 1'b0;
      wr_en[1]     = 1'b0;
      rsp_valid_in = cmd.execute;
      rsp_in       = '0;
      if (cmd.execute) begin
         if (push_req) begin
            if (count_ff[push_cls] == CNT_W'(CLASS_DEPTH)) begin
               rsp_in.status = STATUS_FULL;
            end else begin
               wr_en[push_cls]    = 1'b1;
               tail_in[push_cls]  = next_ptr(tail_ff[push_cls]);
               count_in[push_cls] = count_ff[push_cls] + 1'b1;
               if (arrival_ff == STAMP_W'(STAMP_MOD - 1)) begin
                  arrival_in = '0;
               end else begin
                  arrival_in = arrival_ff + 1'b1;
               end
            end
         end
         if (pop_req) begin
            if (count_ff[pop_cls] == '0) begin
               rsp_in.status = STATUS_EMPTY;
            end else begin
               rsp_in.payload_out  = rd_data[pop_cls][PAYLOAD_WIDTH-1:0];
               rsp_in.popped_class = pop_cls;
               head_in[pop_cls]    = next_ptr(head_ff[pop_cls]);
               count_in[pop_cls]   = count_ff[pop_cls] - 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         req_ff <= req_item;
      end
      rsp_ff <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int c = 0; c < NUM_CLASSES; c++) begin
            head_ff[c]  <= '0;
            tail_ff[c]  <= '0;
            count_ff[c] <= '0;
         end
         arrival_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         count_ff     <= count_in;
         arrival_ff   <= arrival_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

endmodule

[rtl/core/two_class_age_ordered_fifo_unit.sv]
// An accepted start captures the request and moves the state machine to EXEC, where it is
// executed; the result is registered in rsp_valid_ff and rsp_ff, which drive rsp_valid and
// rsp_item. A new start is not taken while busy, which is high in the EXEC state.
// The receiver cannot stall; each result beat is valid for exactly one cycle.
// Reset clears the state machine, the head, tail and count of both classes and the
// arrival counter; RAM contents are left as they are and are read only once written.
module two_class_age_ordered_fifo_unit (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  tcaf_pkg::req_type req_item,
   output logic              rsp_valid,
   output tcaf_pkg::rsp_type rsp_item
);
   import tcaf_pkg::*;

   ctl_cmd_type cmd;

   tcaf_ctrl u_ctrl (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy (busy),
      .cmd  (cmd)
   );

   tcaf_datapath u_datapath (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .req_item (req_item),
      .rsp_valid(rsp_valid),
      .rsp_item (rsp_item)
   );

endmodule

[rtl/core/tcaf_checker.sv]
module tcaf_checker (
   input logic              clock,
   input logic              reset,
   input logic              start,
   input logic              busy,
   input tcaf_pkg::req_type req_item,
   input logic              rsp_valid,
   input tcaf_pkg::rsp_type rsp_item
);
   import tcaf_pkg::*;

   logic accept;

   assign accept = start && !busy;

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      accept |=> busy)
      else $error("busy not raised after an accepted beat");

   a_rsp_after_accept: assert property (@(posedge clock) disable iff (reset)
      accept |-> ##2 rsp_valid)
      else $error("no result beat two cycles after an accepted beat");

   a_rsp_needs_work: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy))
      else $error("result beat without a preceding busy cycle");

   a_fail_zero_fields: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_item.status != STATUS_OK) |->
         (rsp_item.payload_out == '0 && rsp_item.popped_class == 1'b0))
      else $error("failed request returned nonzero fields");

   a_push_no_data: assert property (@(posedge clock) disable iff (reset)
      (accept && (req_item.kind == KIND_PUSH0 || req_item.kind == KIND_PUSH1)) |-> ##2
         (rsp_item.payload_out == '0 && rsp_item.popped_class == 1'b0 &&
          rsp_item.status != STATUS_EMPTY))
      else $error("push returned pop fields");

endmodule

bind two_class_age_ordered_fifo_unit tcaf_checker u_tcaf_checker (
   .clock    (clock),
   .reset    (reset),
   .start    (start),
   .busy     (busy),
   .req_item (req_item),
   .rsp_valid(rsp_valid),
   .rsp_item (rsp_item)
);
